// ----- sv/preemptive_priority_scheduler_unit_macros.svh -----
// Assertion macros shared by the scheduler checker.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PPSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ppsu_pkg.sv -----
// Shared types and constants of the preemptive priority scheduler.
`default_nettype none

package ppsu_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;
    localparam int PRIO_W          = 16;
    localparam int ORDER_W         = 32;

    typedef enum logic [1:0] {
        DEC_NONE    = 2'd0,
        DEC_ASSIGN  = 2'd1,
        DEC_PREEMPT = 2'd2
    } t_decision;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_DECIDE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR
    } t_cmd_kind;

    // Best entry seen so far and whether a free slot was seen, passed cell to cell
    typedef struct packed {
        logic               found;
        logic               free_found;
        logic [ID_W-1:0]    task_id;
        logic [PRIO_W-1:0]  prio;
        logic [ORDER_W-1:0] order;
    } t_cand;

    // Update broadcast to all cells; the addressed cell applies it
    typedef struct packed {
        t_cmd_kind          kind;
        logic [ID_W-1:0]    task_id;
        logic [PRIO_W-1:0]  prio;
        logic [ORDER_W-1:0] order;
    } t_cmd;

endpackage

`default_nettype wire

// ----- sv/preemptive_priority_scheduler_unit.sv -----
// Top level: scan control, decision logic and the chain of queue cells.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  in       | i_in_valid / o_in_ready    | opcode, task id/priority, running task
//  out      | o_out_valid / i_out_ready  | decision, assign id, resign id, queue full
//
// The block takes one item at a time: the scan wave walks one cell per cycle down
// the chain, then the update is applied as the result enters the output register.
// The result sits in an output register; a stalled result holds the block in its
// final step. Reset empties the queue and clears the order counter at once.
`default_nettype none

module preemptive_priority_scheduler_unit #(
    parameter int QUEUE_DEPTH = ppsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_opcode,
    input  wire logic [ppsu_pkg::ID_W-1:0]     i_task_id,
    input  wire logic [ppsu_pkg::PRIO_W-1:0]   i_task_priority,
    input  wire logic                          i_running_valid,
    input  wire logic [ppsu_pkg::ID_W-1:0]     i_running_id,
    input  wire logic [ppsu_pkg::PRIO_W-1:0]   i_running_priority,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_decision,
    output logic [ppsu_pkg::ID_W-1:0]          o_assign_id,
    output logic [ppsu_pkg::ID_W-1:0]          o_resign_id,
    output logic                               o_queue_full
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    ppsu_pkg::t_state              r_state, n_state;
    logic                          r_op;
    logic [ppsu_pkg::ID_W-1:0]     r_tid;
    logic [ppsu_pkg::PRIO_W-1:0]   r_tprio;
    logic                          r_rvalid;
    logic [ppsu_pkg::ID_W-1:0]     r_rid;
    logic [ppsu_pkg::PRIO_W-1:0]   r_rprio;
    ppsu_pkg::t_cand               r_res;
    logic [IDX_W-1:0]              r_res_top;
    logic [IDX_W-1:0]              r_res_free;
    logic [ppsu_pkg::ORDER_W-1:0]  r_next_order, n_next_order;
    logic                          r_out_valid, n_out_valid;
    logic [1:0]                    r_decision, n_decision;
    logic [ppsu_pkg::ID_W-1:0]     r_assign, n_assign;
    logic [ppsu_pkg::ID_W-1:0]     r_resign, n_resign;
    logic                          r_full, n_full;

    logic                          in_acc;
    logic                          load_out;
    ppsu_pkg::t_cmd                cmd;
    logic [IDX_W-1:0]              cmd_idx;

    logic                          w_tok      [QUEUE_DEPTH+1];
    ppsu_pkg::t_cand               w_cand     [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]              w_top_idx  [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]              w_free_idx [QUEUE_DEPTH+1];

    assign o_in_ready = (r_state == ppsu_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Launch the scan wave at the head of the chain with an empty candidate
    assign w_tok[0]      = in_acc;
    assign w_cand[0]     = '0;
    assign w_top_idx[0]  = '0;
    assign w_free_idx[0] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        ppsu_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[g]),
            .i_cand     (w_cand[g]),
            .i_top_idx  (w_top_idx[g]),
            .i_free_idx (w_free_idx[g]),
            .i_cmd      (cmd),
            .i_cmd_idx  (cmd_idx),
            .o_tok      (w_tok[g+1]),
            .o_cand     (w_cand[g+1]),
            .o_top_idx  (w_top_idx[g+1]),
            .o_free_idx (w_free_idx[g+1])
        );
    end

    // Sequence the item and form the decision from the scan result
    always_comb begin
        n_state      = r_state;
        n_next_order = r_next_order;
        n_decision   = ppsu_pkg::DEC_NONE;
        n_assign     = '0;
        n_resign     = '0;
        n_full       = 1'b0;
        cmd          = '{kind: ppsu_pkg::CMD_NONE, task_id: r_rid, prio: r_rprio, order: '0};
        cmd_idx      = r_res_top;
        load_out     = 1'b0;

        if (r_op == ppsu_pkg::OP_ADD) begin
            if (r_res.free_found) begin
                cmd.kind    = ppsu_pkg::CMD_LOAD;
                cmd.task_id = r_tid;
                cmd.prio    = r_tprio;
                cmd.order   = r_next_order;
                cmd_idx     = r_res_free;
            end else begin
                n_full = 1'b1;
            end
        end else if (r_res.found) begin
            n_assign = r_res.task_id;
            if (!r_rvalid) begin
                cmd.kind   = ppsu_pkg::CMD_CLEAR;
                n_decision = ppsu_pkg::DEC_ASSIGN;
            end else if (r_rprio > r_res.prio) begin
                cmd.kind   = ppsu_pkg::CMD_LOAD;
                n_decision = ppsu_pkg::DEC_PREEMPT;
                n_resign   = r_rid;
            end
        end

        unique case (r_state)
            ppsu_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = ppsu_pkg::ST_SCAN;
                end
            end
            ppsu_pkg::ST_SCAN: begin
                if (w_tok[QUEUE_DEPTH]) begin
                    n_state = ppsu_pkg::ST_DONE;
                end
            end
            ppsu_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ppsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ppsu_pkg::ST_IDLE;
            end
        endcase

        // Drop the update unless the result is being committed this cycle
        if (!load_out) begin
            cmd.kind = ppsu_pkg::CMD_NONE;
        end
        if (load_out && (r_op == ppsu_pkg::OP_ADD) && r_res.free_found) begin
            n_next_order = r_next_order + 1'b1;
        end

        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ppsu_pkg::ST_IDLE;
            r_next_order <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next_order <= n_next_order;
            r_out_valid  <= n_out_valid;
        end
    end

    // Hold the accepted beat for the length of the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_opcode;
            r_tid    <= i_task_id;
            r_tprio  <= i_task_priority;
            r_rvalid <= i_running_valid;
            r_rid    <= i_running_id;
            r_rprio  <= i_running_priority;
        end
    end

    // Capture the scan result at the tail of the chain
    always_ff @(posedge i_clk) begin
        if ((r_state == ppsu_pkg::ST_SCAN) && w_tok[QUEUE_DEPTH]) begin
            r_res      <= w_cand[QUEUE_DEPTH];
            r_res_top  <= w_top_idx[QUEUE_DEPTH];
            r_res_free <= w_free_idx[QUEUE_DEPTH];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_decision <= n_decision;
            r_assign   <= n_assign;
            r_resign   <= n_resign;
            r_full     <= n_full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_decision   = r_decision;
    assign o_assign_id  = r_assign;
    assign o_resign_id  = r_resign;
    assign o_queue_full = r_full;

endmodule

`default_nettype wire

// ----- sv/ppsu_cell.sv -----
// One queue slot: holds a task and folds it into the scan wave passing by.
`default_nettype none

module ppsu_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tok,
    input  wire ppsu_pkg::t_cand  i_cand,
    input  wire logic [IDX_W-1:0] i_top_idx,
    input  wire logic [IDX_W-1:0] i_free_idx,
    input  wire ppsu_pkg::t_cmd   i_cmd,
    input  wire logic [IDX_W-1:0] i_cmd_idx,
    output logic                  o_tok,
    output ppsu_pkg::t_cand       o_cand,
    output logic [IDX_W-1:0]      o_top_idx,
    output logic [IDX_W-1:0]      o_free_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                         r_valid;
    logic [ppsu_pkg::ID_W-1:0]    r_task;
    logic [ppsu_pkg::PRIO_W-1:0]  r_prio;
    logic [ppsu_pkg::ORDER_W-1:0] r_order;

    logic                         r_tok;
    ppsu_pkg::t_cand              r_cand;
    logic [IDX_W-1:0]             r_top_idx;
    logic [IDX_W-1:0]             r_free_idx;

    ppsu_pkg::t_cand              n_cand;
    logic [IDX_W-1:0]             n_top_idx;
    logic [IDX_W-1:0]             n_free_idx;
    logic                         better;
    logic                         hit;

    // Fold this slot into the candidate; strict compare keeps the lower index on ties
    always_comb begin
        better = r_valid && (!i_cand.found || (r_prio < i_cand.prio) ||
                 ((r_prio == i_cand.prio) && (r_order < i_cand.order)));
        n_cand     = i_cand;
        n_top_idx  = i_top_idx;
        n_free_idx = i_free_idx;
        if (better) begin
            n_cand.found   = 1'b1;
            n_cand.task_id = r_task;
            n_cand.prio    = r_prio;
            n_cand.order   = r_order;
            n_top_idx      = MY_IDX;
        end
        if (!r_valid && !i_cand.free_found) begin
            n_cand.free_found = 1'b1;
            n_free_idx        = MY_IDX;
        end
    end

    assign hit = (i_cmd_idx == MY_IDX);

    // Advance the scan wave to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
        r_cand     <= n_cand;
        r_top_idx  <= n_top_idx;
        r_free_idx <= n_free_idx;
    end

    // Apply the broadcast update when addressed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (hit && (i_cmd.kind == ppsu_pkg::CMD_LOAD)) begin
            r_valid <= 1'b1;
        end else if (hit && (i_cmd.kind == ppsu_pkg::CMD_CLEAR)) begin
            r_valid <= 1'b0;
        end
        if (hit && (i_cmd.kind == ppsu_pkg::CMD_LOAD)) begin
            r_task  <= i_cmd.task_id;
            r_prio  <= i_cmd.prio;
            r_order <= i_cmd.order;
        end
    end

    assign o_tok      = r_tok;
    assign o_cand     = r_cand;
    assign o_top_idx  = r_top_idx;
    assign o_free_idx = r_free_idx;

endmodule

`default_nettype wire

// ----- sv/ppsu_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none
`include "preemptive_priority_scheduler_unit_macros.svh"

module ppsu_port_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [1:0]                  o_decision,
    input wire logic [ppsu_pkg::ID_W-1:0]   o_assign_id,
    input wire logic [ppsu_pkg::ID_W-1:0]   o_resign_id,
    input wire logic                        o_queue_full
);

    // A dropped add reports nothing else
    `PPSU_ASSERT_NOW(a_full_quiet, i_clk, i_rst_n, o_out_valid && o_queue_full,
        (o_decision == ppsu_pkg::DEC_NONE) && (o_assign_id == '0) && (o_resign_id == '0),
        "queue_full beat carries a decision")

    // Only a preemption names a resigned task
    `PPSU_ASSERT_NOW(a_resign_only_preempt, i_clk, i_rst_n,
        o_out_valid && (o_decision != ppsu_pkg::DEC_PREEMPT), o_resign_id == '0,
        "resign id without preemption")

    // One item at a time: an accept closes the input until the result is committed
    `PPSU_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "input ready right after an accept")

    // A stalled result beat holds
    `PPSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_decision) && $stable(o_assign_id),
        "stalled result beat changed")

endmodule

bind preemptive_priority_scheduler_unit ppsu_port_checker u_ppsu_checker (.*);

`default_nettype wire

// ----- tb/ppsu_checker.sv -----
// Scoreboard for the scheduler: predicts each decision and compares every result beat.
module ppsu_checker #(
    parameter int QUEUE_DEPTH = ppsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_opcode,
    input  logic [ppsu_pkg::ID_W-1:0]       i_task_id,
    input  logic [ppsu_pkg::PRIO_W-1:0]     i_task_priority,
    input  logic                            i_running_valid,
    input  logic [ppsu_pkg::ID_W-1:0]       i_running_id,
    input  logic [ppsu_pkg::PRIO_W-1:0]     i_running_priority,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      i_decision,
    input  logic [ppsu_pkg::ID_W-1:0]       i_assign_id,
    input  logic [ppsu_pkg::ID_W-1:0]       i_resign_id,
    input  logic                            i_queue_full,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_preempts,
    output int                              o_assigns,
    output int                              o_drops
);

    typedef struct packed {
        ppsu_pkg::t_decision            decision;
        logic [ppsu_pkg::ID_W-1:0]      assign_id;
        logic [ppsu_pkg::ID_W-1:0]      resign_id;
        logic                           queue_full;
    } sched_result_t;

    // Shadow copy of the ready queue
    logic                             slot_used [QUEUE_DEPTH];
    logic [ppsu_pkg::PRIO_W-1:0]      slot_prio [QUEUE_DEPTH];
    logic [ppsu_pkg::ORDER_W-1:0]     slot_seq  [QUEUE_DEPTH];
    logic [ppsu_pkg::ID_W-1:0]        slot_id   [QUEUE_DEPTH];
    logic [ppsu_pkg::ORDER_W-1:0]     seq_next;

    sched_result_t sched_expected [$];

    int mismatch_total = 0;
    int results_seen   = 0;
    int preempt_total  = 0;
    int assign_total   = 0;
    int drop_total     = 0;

    // Print one mismatch line (only the first 20) and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_total < 20) begin
            $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
        mismatch_total++;
    endtask

    // Apply one input beat to the shadow queue and return the result it must produce
    function automatic sched_result_t predict_schedule(
        input logic                         op,
        input logic [ppsu_pkg::ID_W-1:0]    tid,
        input logic [ppsu_pkg::PRIO_W-1:0]  tprio,
        input logic                         rvalid,
        input logic [ppsu_pkg::ID_W-1:0]    rid,
        input logic [ppsu_pkg::PRIO_W-1:0]  rprio
    );
        sched_result_t res;
        int            best;
        int            free_idx;
        res = '0;
        res.decision = ppsu_pkg::DEC_NONE;
        best = -1;
        free_idx = -1;
        if (ppsu_pkg::t_opcode'(op) == ppsu_pkg::OP_ADD) begin
            // take the lowest free slot, drop the task when none is left
            for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
                if (!slot_used[k]) free_idx = k;
            end
            if (free_idx < 0) begin
                res.queue_full = 1'b1;
            end else begin
                slot_used[free_idx] = 1'b1;
                slot_id[free_idx]   = tid;
                slot_prio[free_idx] = tprio;
                slot_seq[free_idx]  = seq_next;
                seq_next            = seq_next + 1'b1;
            end
        end else begin
            // find the most urgent entry; strict compares keep the lowest slot on a full tie
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if (slot_used[k]) begin
                    if (best < 0 || slot_prio[k] < slot_prio[best] ||
                        (slot_prio[k] == slot_prio[best] && slot_seq[k] < slot_seq[best])) begin
                        best = k;
                    end
                end
            end
            if (best >= 0) begin
                res.assign_id = slot_id[best];
                if (!rvalid) begin
                    slot_used[best] = 1'b0;
                    res.decision = ppsu_pkg::DEC_ASSIGN;
                end else if (rprio > slot_prio[best]) begin
                    // swap the running task into the popped slot with order zero
                    res.decision    = ppsu_pkg::DEC_PREEMPT;
                    res.resign_id   = rid;
                    slot_id[best]   = rid;
                    slot_prio[best] = rprio;
                    slot_seq[best]  = '0;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        sched_result_t want;
        if (!i_rst_n) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) slot_used[k] = 1'b0;
            seq_next = '0;
            sched_expected.delete();
        end else begin
            // compare the result beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (sched_expected.size() == 0) begin
                    report_mismatch("result beat with nothing pending, assign_id",
                                    32'(i_assign_id), 32'd0);
                end else begin
                    want = sched_expected.pop_front();
                    if (i_decision !== want.decision)
                        report_mismatch("decision", 32'(i_decision), 32'(want.decision));
                    if (i_assign_id !== want.assign_id)
                        report_mismatch("assign_id", 32'(i_assign_id), 32'(want.assign_id));
                    if (i_resign_id !== want.resign_id)
                        report_mismatch("resign_id", 32'(i_resign_id), 32'(want.resign_id));
                    if (i_queue_full !== want.queue_full)
                        report_mismatch("queue_full", 32'(i_queue_full), 32'(want.queue_full));
                    results_seen++;
                end
            end
            // predict on every accepted input beat
            if (i_in_valid && i_in_ready) begin
                want = predict_schedule(i_opcode, i_task_id, i_task_priority,
                                        i_running_valid, i_running_id, i_running_priority);
                sched_expected.push_back(want);
                if (want.decision == ppsu_pkg::DEC_PREEMPT) preempt_total++;
                if (want.decision == ppsu_pkg::DEC_ASSIGN) assign_total++;
                if (want.queue_full) drop_total++;
            end
        end
        o_pending    <= sched_expected.size();
        o_fail_count <= mismatch_total;
        o_results    <= results_seen;
        o_preempts   <= preempt_total;
        o_assigns    <= assign_total;
        o_drops      <= drop_total;
    end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the scheduler: clock, reset, stimulus, result back-pressure and verdict.
module testbench;

    localparam int     DEPTH        = ppsu_pkg::QUEUE_DEPTH_DEF;
    localparam int     RANDOM_ITEMS = 1700;
    localparam int     MAX_GAP      = 18;
    localparam int     DRAIN_CYCLES = DEPTH + 8;
    localparam longint CYCLE_LIMIT  = 500000;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          in_ready;
    logic                          opcode     = 1'b0;
    logic [ppsu_pkg::ID_W-1:0]     task_id    = '0;
    logic [ppsu_pkg::PRIO_W-1:0]   task_prio  = '0;
    logic                          run_valid  = 1'b0;
    logic [ppsu_pkg::ID_W-1:0]     run_id     = '0;
    logic [ppsu_pkg::PRIO_W-1:0]   run_prio   = '0;
    logic                          out_valid;
    logic                          out_ready  = 1'b0;
    logic [1:0]                    decision;
    logic [ppsu_pkg::ID_W-1:0]     assign_id;
    logic [ppsu_pkg::ID_W-1:0]     resign_id;
    logic                          queue_full;

    int     fail_count;
    int     pending;
    int     results;
    int     preempts;
    int     assigns;
    int     drops;
    int     items_sent = 0;
    longint cycles     = 0;
    bit     tx_nogap   = 1'b0;
    bit     rx_nostall = 1'b0;

    always #5 clk = ~clk;

    preemptive_priority_scheduler_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_opcode           (opcode),
        .i_task_id          (task_id),
        .i_task_priority    (task_prio),
        .i_running_valid    (run_valid),
        .i_running_id       (run_id),
        .i_running_priority (run_prio),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_decision         (decision),
        .o_assign_id        (assign_id),
        .o_resign_id        (resign_id),
        .o_queue_full       (queue_full)
    );

    ppsu_checker #(
        .QUEUE_DEPTH (DEPTH)
    ) u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_opcode           (opcode),
        .i_task_id          (task_id),
        .i_task_priority    (task_prio),
        .i_running_valid    (run_valid),
        .i_running_id       (run_id),
        .i_running_priority (run_prio),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_decision         (decision),
        .i_assign_id        (assign_id),
        .i_resign_id        (resign_id),
        .i_queue_full       (queue_full),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_results          (results),
        .o_preempts         (preempts),
        .o_assigns          (assigns),
        .o_drops            (drops)
    );

    // Favor a few small priorities so ties and equal-urgency decisions are common
    function automatic logic [ppsu_pkg::PRIO_W-1:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return ppsu_pkg::PRIO_W'($urandom_range(0, 7));
        if (sel == 4) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return ppsu_pkg::PRIO_W'($urandom);
    endfunction

    // Wait a random gap, then hold one input beat until it is accepted
    task automatic send_beat(
        input ppsu_pkg::t_opcode            op,
        input logic [ppsu_pkg::ID_W-1:0]    tid,
        input logic [ppsu_pkg::PRIO_W-1:0]  tprio,
        input logic                         rv,
        input logic [ppsu_pkg::ID_W-1:0]    rid,
        input logic [ppsu_pkg::PRIO_W-1:0]  rprio
    );
        int gap;
        if ($urandom_range(0, 39) == 0) tx_nogap = !tx_nogap;
        gap = tx_nogap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode    <= op;
        task_id   <= tid;
        task_prio <= tprio;
        run_valid <= rv;
        run_id    <= rid;
        run_prio  <= rprio;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Stop the run if it hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycles, pending);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Back-pressure the result channel with random stalls after each beat
    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_nostall = !rx_nostall;
            stall = rx_nostall ? 0 : $urandom_range(0, MAX_GAP);
            if (stall == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (stall - 1) @(posedge clk);
                out_ready <= 1'b1;
            end
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin
        int n_add;
        int n_dec;
        int pop_pct;
        int rand_start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // decide on an empty queue, with and without a running task
        send_beat(ppsu_pkg::OP_DECIDE, '0, '0, 1'b0, '0, '0);
        send_beat(ppsu_pkg::OP_DECIDE, '1, '1, 1'b1, '1, '0);
        // field extremes, then an equally urgent running task and a plain pop
        send_beat(ppsu_pkg::OP_ADD, '1, '1, 1'b1, '1, '1);
        send_beat(ppsu_pkg::OP_ADD, '0, '0, 1'b0, '0, '0);
        send_beat(ppsu_pkg::OP_DECIDE, '0, '0, 1'b1, 16'h1234, '0);
        send_beat(ppsu_pkg::OP_DECIDE, '0, '0, 1'b0, '0, '0);
        // same priority: arrival order picks the top; two preemptions leave a full tie
        send_beat(ppsu_pkg::OP_ADD, 16'd5, 16'd10, 1'b0, '0, '0);
        send_beat(ppsu_pkg::OP_ADD, 16'd6, 16'd10, 1'b0, '0, '0);
        send_beat(ppsu_pkg::OP_DECIDE, '0, '0, 1'b1, 16'hAAAA, 16'd20);
        send_beat(ppsu_pkg::OP_DECIDE, '0, '0, 1'b1, 16'hBBBB, 16'd20);
        send_beat(ppsu_pkg::OP_DECIDE, '0, '0, 1'b0, '0, '0);
        // fill the queue and overflow it, preempt while full, overflow again
        repeat (15) send_beat(ppsu_pkg::OP_ADD, ppsu_pkg::ID_W'($urandom), pick_prio(),
                              1'b0, '0, '0);
        send_beat(ppsu_pkg::OP_DECIDE, '0, '0, 1'b1, 16'h5A5A, '1);
        send_beat(ppsu_pkg::OP_ADD, 16'h7777, 16'd1, 1'b1, '1, '1);

        // random bursts of adds then decides, with varying pop pressure
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            n_add = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 12);
            n_dec = $urandom_range(1, 20);
            pop_pct = 10 + 30 * $urandom_range(0, 3);
            repeat (n_add) begin
                send_beat(ppsu_pkg::OP_ADD, ppsu_pkg::ID_W'($urandom), pick_prio(),
                          1'($urandom_range(0, 1)), ppsu_pkg::ID_W'($urandom),
                          ppsu_pkg::PRIO_W'($urandom));
            end
            repeat (n_dec) begin
                send_beat(ppsu_pkg::OP_DECIDE, ppsu_pkg::ID_W'($urandom),
                          ppsu_pkg::PRIO_W'($urandom),
                          1'($urandom_range(0, 99) >= pop_pct),
                          ppsu_pkg::ID_W'($urandom), pick_prio());
            end
            // sprinkle in fully random beats
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(ppsu_pkg::t_opcode'($urandom_range(0, 1)),
                              ppsu_pkg::ID_W'($urandom), ppsu_pkg::PRIO_W'($urandom),
                              1'($urandom_range(0, 1)), ppsu_pkg::ID_W'($urandom),
                              ppsu_pkg::PRIO_W'($urandom));
                end
            end
        end
        in_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input beats and checked %0d result beats.", items_sent, results);
        $display("Covered %0d preemptions, %0d pops to an idle core, %0d adds dropped when full.",
                 preempts, assigns, drops);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ppsu_pkg.sv
sv/ppsu_cell.sv
sv/preemptive_priority_scheduler_unit.sv
sv/ppsu_checker.sv
tb/ppsu_checker.sv
tb/testbench.sv
